/* hdl/gsfp_pkg.sv */
// Shared types and constants for the gas sensor frame parser.
// No dependencies; imported by every module of the block.
package gsfp_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h2C;
    localparam logic [7:0] HDR_SECOND  = 8'hE4;
    localparam int         PAYLOAD_LEN = 6;
    localparam int         CNT_W       = $clog2(PAYLOAD_LEN);

    // Frame queue between the hunter and the output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded frame; tvoc sits in the lowest bits to match the stream packing
    typedef struct packed {
        logic [15:0] eco2_level;
        logic [15:0] hcho_level;
        logic [15:0] tvoc_level;
    } reading_t;

    typedef struct packed {
        logic     valid;
        reading_t reading;
    } push_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

/* hdl/gsfp_front.sv */
// Frame hunter: tracks header, payload and checksum and pushes good frames.
// Depends on gsfp_pkg.
module gsfp_front
    import gsfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output push_t      push
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SECOND,
        ST_PAYLOAD,
        ST_CHECK
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [7:0]                    sum_reg, sum_next;
    logic [PAYLOAD_LEN*8-1:0]      data_reg, data_next;
    logic                          push_valid_next;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        data_next       = data_reg;
        push_valid_next = 1'b0;
        if (byte_valid)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    cnt_next = '0;
                    if (rx_byte == HDR_FIRST)
                    begin
                        sum_next   = rx_byte;
                        state_next = ST_SECOND;
                    end
                end
                ST_SECOND:
                begin
                    // a wrong second byte is not rechecked as a header
                    if (rx_byte == HDR_SECOND)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        state_next = ST_PAYLOAD;
                    end
                    else
                    begin
                        sum_next   = '0;
                        state_next = ST_HUNT;
                    end
                end
                ST_PAYLOAD:
                begin
                    data_next = {data_reg[PAYLOAD_LEN*8-9:0], rx_byte};
                    sum_next  = sum_reg + rx_byte;
                    if (cnt_reg == CNT_W'(PAYLOAD_LEN - 1))
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    push_valid_next = (rx_byte == sum_reg);
                    sum_next        = '0;
                    state_next      = ST_HUNT;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Push the frame in the cycle its checksum byte is taken
    always_comb
    begin
        push.valid              = push_valid_next;
        push.reading.tvoc_level = data_reg[47:32];
        push.reading.hcho_level = data_reg[31:16];
        push.reading.eco2_level = data_reg[15:0];
    end

endmodule

/* hdl/gsfp_queue.sv */
// Short frame queue that decouples the hunter from the output stage.
// Depends on gsfp_pkg.
module gsfp_queue
    import gsfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    input  logic          pop,
    output reading_t      head,
    output queue_status_t status
);

    reading_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.reading;
        end
    end

endmodule

/* hdl/gsfp_back.sv */
// Output stage: holds one reading in a register and presents it downstream.
// Depends on gsfp_pkg.
module gsfp_back
    import gsfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  reading_t      head,
    input  queue_status_t status,
    output logic          pop,
    output logic          out_valid,
    output reading_t      out_reading,
    input  logic          out_ready
);

    logic     valid_reg;
    reading_t data_reg;

    // Refill when the register is empty or its reading leaves this cycle
    assign pop         = !status.empty && (!valid_reg || out_ready);
    assign out_valid   = valid_reg;
    assign out_reading = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

endmodule

/* hdl/gas_sensor_frame_parser.sv */
// Top level of the gas sensor frame parser: hunter, frame queue, output stage.
// Depends on gsfp_pkg, gsfp_front, gsfp_queue and gsfp_back.
//
// Usage:
//   s_axis carries one received serial byte per transfer. The block hunts for
//   a 9-byte frame (0x2C, 0xE4, six payload bytes, additive checksum of the
//   first eight bytes). A wrong second byte returns to hunting without being
//   rechecked as a header. A frame with a bad checksum is dropped silently.
//   m_axis carries one transfer per good frame with the three big-endian
//   readings TVOC, formaldehyde and eCO2.
//   Throughput: one byte per cycle while the frame queue is not full; the hunter works on a byte in
//   the cycle it is taken.
//   Path: the checksum byte transfer writes the frame queue; the output register
//   loads the queue head when the register is empty or its reading is taken,
//   so a low m_axis_tready keeps the reading waiting in the queue.
//   Stall: a two-entry queue sits in front of the output register, so three
//   frames may wait while m_axis_tready is low. Only when the queue is full
//   does s_axis_tready drop; no byte and no frame is lost.
//   Reset: rst_n clears the hunter to hunting and empties queue and output.
module gas_sensor_frame_parser
    import gsfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] tvoc_level, [31:16] hcho_level,
                                        // [47:32] eco2_level
);

    push_t         push;
    reading_t      head;
    reading_t      out_reading;
    queue_status_t q_status;
    logic          pop;
    logic          byte_take;

    // Hold input while the queue cannot take a frame
    assign s_axis_tready = !q_status.full;
    assign byte_take     = s_axis_tvalid && s_axis_tready;

    gsfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .rx_byte    (s_axis_tdata),
        .push       (push)
    );

    gsfp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    gsfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (q_status),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_reading (out_reading),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = out_reading;

    // Queue occupancy never exceeds its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("frame queue overfilled");

    // A frame is only pushed when the queue has room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_status.full)
        else $error("frame pushed into full queue");

    // A pushed frame is waiting somewhere on the next cycle
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> (!q_status.empty || m_axis_tvalid))
        else $error("pushed frame lost");

endmodule

/* tb/tb_gas_sensor_frame_parser.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gas_sensor_frame_parser: a serial byte stream of frames,
// broken frames and noise against an in-bench frame decoder. Depends on gsfp_pkg and the RTL.
module tb_gas_sensor_frame_parser;
    import gsfp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int BYTE_TARGET  = 1700;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the frame queue
    localparam int HOLD_AFTER   = 20;    // readings to see before the hold-off starts
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 8;     // margin after the drain before missing readings are reported
    localparam int CHECK_POS    = 8;

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [15:0] tvoc, [31:16] hcho, [47:32] eco2

    gas_sensor_frame_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Serial bytes waiting to be sent, and readings the decoder says must come out
    logic [7:0] pending_bytes[$];
    reading_t   expected_readings[$];

    // Decoder state: position in the frame, running checksum, captured payload
    logic [3:0] hunt_pos;
    logic [7:0] hunt_sum;
    logic [7:0] payload_seen[PAYLOAD_LEN];

    int mismatch_count   = 0;
    int bytes_accepted   = 0;
    int readings_checked = 0;
    int frames_dropped   = 0;
    bit input_stalled    = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;

    logic     hold_active = 1'b0;
    logic     hold_done   = 1'b0;
    int       hold_count  = 0;
    rx_mode_t rx_mode     = RX_STEADY;
    int       mode_left   = 0;

    // Advance the frame decoder by one byte; returns 1 when a good frame completes
    function automatic logic decode_byte(input logic [7:0] rx, output reading_t done);
        logic [3:0] pos;
        logic       good;
        pos  = (hunt_pos > CHECK_POS) ? 4'd0 : hunt_pos;
        good = 1'b0;
        done = '0;
        if (pos == 4'd0) begin
            if (rx == HDR_FIRST) begin
                hunt_sum = rx;
                hunt_pos = 4'd1;
            end
            else begin
                hunt_pos = 4'd0;
            end
        end
        else if (pos == 4'd1) begin
            // a wrong second byte is dropped, never re-tried as a header
            if (rx == HDR_SECOND) begin
                hunt_sum = hunt_sum + rx;
                hunt_pos = 4'd2;
            end
            else begin
                hunt_sum = 8'h00;
                hunt_pos = 4'd0;
            end
        end
        else if (pos < CHECK_POS) begin
            payload_seen[3'(pos - 4'd2)] = rx;
            hunt_sum = hunt_sum + rx;
            hunt_pos = pos + 4'd1;
        end
        else begin
            good     = (rx == hunt_sum);
            hunt_pos = 4'd0;
            hunt_sum = 8'h00;
            done.tvoc_level = {payload_seen[0], payload_seen[1]};
            done.hcho_level = {payload_seen[2], payload_seen[3]};
            done.eco2_level = {payload_seen[4], payload_seen[5]};
            if (!good)
                frames_dropped++;
        end
        return good;
    endfunction

    task automatic report_reading(input string what, input reading_t want, input reading_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected tvoc=%h hcho=%h eco2=%h, got tvoc=%h hcho=%h eco2=%h",
                     $time, what, want.tvoc_level, want.hcho_level, want.eco2_level,
                     got.tvoc_level, got.hcho_level, got.eco2_level);
    endtask

    // Queue a frame; a nonzero sum_flip corrupts the checksum, keep < 9 truncates it
    task automatic push_frame(input logic [47:0] payload, input logic [7:0] sum_flip,
                              input int keep);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        for (int i = 0; i < keep; i++) begin
            if (i == 0)
                b = HDR_FIRST;
            else if (i == 1)
                b = HDR_SECOND;
            else if (i < CHECK_POS)
                b = payload[47 - 8 * (i - 2) -: 8];
            else
                b = sum ^ sum_flip;
            sum = sum + b;
            pending_bytes.push_back(b);
        end
    endtask

    // Mostly random bytes, with the extremes mixed in
    function automatic logic [47:0] random_payload();
        logic [47:0] p;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case ($urandom_range(0, 7))
                0:       p[8 * i +: 8] = 8'h00;
                1:       p[8 * i +: 8] = 8'hFF;
                default: p[8 * i +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    // Driver: send pending bytes in bursts of random length with random gaps
    always @(posedge clk or negedge rst_n) begin : drive_bytes
        logic       offer;
        logic [7:0] next_byte;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            offer     = 1'b0;
            next_byte = s_axis_tdata;
            if (gap_left > 0) begin
                gap_left--;
            end
            else if (pending_bytes.size() > 0) begin
                next_byte = pending_bytes.pop_front();
                offer     = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end
                else begin
                    // mostly short bursts, now and then a long unbroken stretch
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= next_byte;
        end
    end

    // Long hold-off: counted in its own process, starts once results are flowing
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_count  <= 0;
        end
        else if (hold_active) begin
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end
        else if (!hold_done && readings_checked >= HOLD_AFTER) begin
            hold_active <= 1'b1;
        end
    end

    // Receiver: stall on a pattern that changes mode at random intervals, and hold off during the long hold-off
    always @(posedge clk or negedge rst_n) begin : drive_ready
        logic ready_next;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 160);
            end
            else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STEADY:    ready_next = 1'b1;
                RX_LIGHT:     ready_next = ($urandom_range(0, 9) < 7);
                RX_HEAVY:     ready_next = ($urandom_range(0, 9) < 3);
                default:      ready_next = ~m_axis_tready;
            endcase
            m_axis_tready <= ready_next && !hold_active;
        end
    end

    // Monitor: feed every byte transfer to the decoder, check every reading transfer
    always @(posedge clk) begin : watch_streams
        reading_t want;
        reading_t got;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_accepted++;
                if (decode_byte(s_axis_tdata, want))
                    expected_readings.push_back(want);
            end
            if (hold_active && s_axis_tvalid && !s_axis_tready)
                input_stalled = 1'b1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_readings.size() == 0) begin
                    report_reading("unexpected reading", '0, got);
                end
                else begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    if (got.tvoc_level !== want.tvoc_level || got.hcho_level !== want.hcho_level
                        || got.eco2_level !== want.eco2_level)
                        report_reading("reading mismatch", want, got);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : run_frames
        int       frame_bytes;
        int       pick;
        int       noise;
        reading_t none;
        hunt_pos    = 4'd0;
        hunt_sum    = 8'h00;
        none        = '0;
        frame_bytes = 0;
        for (int i = 0; i < PAYLOAD_LEN; i++)
            payload_seen[i] = 8'h00;

        // Directed: all-ones frame, wrong second byte that is itself a header,
        // all-zero frame, then a frame with a bad checksum
        push_frame({6{8'hFF}}, 8'h00, 9);
        pending_bytes.push_back(HDR_FIRST);
        pending_bytes.push_back(HDR_FIRST);
        pending_bytes.push_back(HDR_SECOND);
        push_frame({6{8'h00}}, 8'h00, 9);
        push_frame(48'h0123_4567_89AB, 8'h01, 9);

        // Random: mostly good frames, plus bad sums, broken headers, truncation and noise
        while (frame_bytes < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                push_frame(random_payload(), 8'h00, 9);
                frame_bytes += 9;
            end
            else if (pick < 82) begin
                push_frame(random_payload(), 8'($urandom_range(1, 255)), 9);
                frame_bytes += 9;
            end
            else if (pick < 88) begin
                pending_bytes.push_back(HDR_FIRST);
                pending_bytes.push_back(($urandom_range(0, 1) == 0) ? HDR_FIRST
                                                                    : 8'($urandom_range(0, 227)));
                frame_bytes += 2;
            end
            else if (pick < 92) begin
                noise = $urandom_range(3, 8);
                push_frame(random_payload(), 8'h00, noise);
                frame_bytes += noise;
            end
            else begin
                noise = $urandom_range(1, 6);
                for (int i = 0; i < noise; i++)
                    pending_bytes.push_back(8'($urandom));
                frame_bytes += noise;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        for (int i = 0; i < DRAIN_LIMIT && expected_readings.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (expected_readings.size() != 0)
            report_reading("missing reading", expected_readings.pop_front(), none);

        $display("Sent %0d serial bytes; %0d readings checked, %0d bad-checksum frames dropped.",
                 bytes_accepted, readings_checked, frames_dropped);
        $display("Input back-pressure during the long receiver hold-off: %s; mismatches: %0d.",
                 input_stalled ? "seen" : "not seen", mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Run did not finish in time.");
        $display("TB_ERROR");
        $finish;
    end

endmodule
